@@ sv/lts_pkg.sv @@
package lts_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF   = 4;
	localparam int TOK_PER_BYTE      = 3;

	localparam logic [4:0] K_LPAREN  = 5'd0;
	localparam logic [4:0] K_RPAREN  = 5'd1;
	localparam logic [4:0] K_MINUS   = 5'd2;
	localparam logic [4:0] K_PLUS    = 5'd3;
	localparam logic [4:0] K_STAR    = 5'd4;
	localparam logic [4:0] K_SLASH   = 5'd5;
	localparam logic [4:0] K_EQEQ    = 5'd6;
	localparam logic [4:0] K_LT      = 5'd7;
	localparam logic [4:0] K_LE      = 5'd8;
	localparam logic [4:0] K_GT      = 5'd9;
	localparam logic [4:0] K_GE      = 5'd10;
	localparam logic [4:0] K_QUOTE   = 5'd11;
	localparam logic [4:0] K_STRING  = 5'd12;
	localparam logic [4:0] K_NUMBER  = 5'd13;
	localparam logic [4:0] K_IDENT   = 5'd14;
	localparam logic [4:0] K_NIL     = 5'd15;
	localparam logic [4:0] K_DEFINE  = 5'd16;
	localparam logic [4:0] K_SET     = 5'd17;
	localparam logic [4:0] K_END     = 5'd18;
	localparam logic [4:0] K_ERRCHAR = 5'd19;
	localparam logic [4:0] K_ERRSTR  = 5'd20;

	typedef enum logic [10:0] {
		M_IDLE    = 11'b000_0000_0001,
		M_LPAREN  = 11'b000_0000_0010,
		M_EQ      = 11'b000_0000_0100,
		M_LT      = 11'b000_0000_1000,
		M_GT      = 11'b000_0001_0000,
		M_NUM     = 11'b000_0010_0000,
		M_NUMDOT  = 11'b000_0100_0000,
		M_FRAC    = 11'b000_1000_0000,
		M_IDENT   = 11'b001_0000_0000,
		M_STRING  = 11'b010_0000_0000,
		M_COMMENT = 11'b100_0000_0000
	} mode_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic [15:0] token_line;
		logic        last_of_run;
	} out_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
	} tok_t;

	typedef struct packed {
		tok_t [TOK_PER_BYTE-1:0] toks;
		logic [1:0]              count;
		logic [15:0]             line;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ sv/lts_front.sv @@
module lts_front #(
	parameter int POSITION_BITS = lts_pkg::POSITION_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  lts_pkg::in_t    byte_data,
	input  lts_pkg::q_stat_t q_stat,
	output logic            push,
	output lts_pkg::bundle_t bundle
);
	import lts_pkg::*;

	localparam int P     = POSITION_BITS;
	localparam int EXT_W = (P > 16) ? P : 16;
	localparam logic [P-1:0] POS_MAX = {P{1'b1}};
	localparam logic [P-1:0] POS_ONE = P'(1);

	localparam logic [3:0] KW_NONE   = 4'd0;
	localparam logic [3:0] KW_N      = 4'd1;
	localparam logic [3:0] KW_NI     = 4'd2;
	localparam logic [3:0] KW_NIL    = 4'd3;
	localparam logic [3:0] KW_D      = 4'd4;
	localparam logic [3:0] KW_DE     = 4'd5;
	localparam logic [3:0] KW_DEF    = 4'd6;
	localparam logic [3:0] KW_DEFI   = 4'd7;
	localparam logic [3:0] KW_DEFIN  = 4'd8;
	localparam logic [3:0] KW_DEFINE = 4'd9;
	localparam logic [3:0] KW_S      = 4'd10;
	localparam logic [3:0] KW_SE     = 4'd11;
	localparam logic [3:0] KW_SET    = 4'd12;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_QMARK  = 8'h3F;

	mode_t          mode_q, mode_n;
	logic [P-1:0]   begin_q, begin_n;
	logic [P-1:0]   pos_q, pos_n;
	logic [15:0]    line_q, line_n;
	logic [3:0]     kw_q, kw_n;

	logic [P-1:0]   pos_inc, cur_len, two;
	logic [15:0]    line_inc;
	logic [7:0]     c, lc;
	logic           accept, fall, do_flush;
	logic [1:0]     cnt;
	bundle_t        b;
	logic [4:0]     ident_kind;

	function automatic logic [15:0] sat16(input logic [P-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return (e > EXT_W'(16'hFFFF)) ? 16'hFFFF : e[15:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] ch);
		return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A)) ||
			(ch == CH_UNDER) || (ch == CH_QMARK);
	endfunction

	function automatic logic [3:0] kw_first(input logic [7:0] ch);
		unique case (ch)
			8'h6E:   return KW_N;
			8'h64:   return KW_D;
			8'h73:   return KW_S;
			default: return KW_NONE;
		endcase
	endfunction

	function automatic logic [3:0] kw_next(input logic [3:0] s, input logic [7:0] ch);
		unique case (s)
			KW_N:     return (ch == 8'h69) ? KW_NI : KW_NONE;
			KW_NI:    return (ch == 8'h6C) ? KW_NIL : KW_NONE;
			KW_D:     return (ch == 8'h65) ? KW_DE : KW_NONE;
			KW_DE:    return (ch == 8'h66) ? KW_DEF : KW_NONE;
			KW_DEF:   return (ch == 8'h69) ? KW_DEFI : KW_NONE;
			KW_DEFI:  return (ch == 8'h6E) ? KW_DEFIN : KW_NONE;
			KW_DEFIN: return (ch == 8'h65) ? KW_DEFINE : KW_NONE;
			KW_S:     return (ch == 8'h65) ? KW_SE : KW_NONE;
			KW_SE:    return (ch == 8'h74) ? KW_SET : KW_NONE;
			default:  return KW_NONE;
		endcase
	endfunction

	assign byte_stall = q_stat.full;
	assign accept     = byte_valid && !q_stat.full;
	assign c          = byte_data.char_code;
	assign lc         = ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;

	always_comb begin
		unique case (kw_q)
			KW_NIL:    ident_kind = K_NIL;
			KW_DEFINE: ident_kind = K_DEFINE;
			KW_SET:    ident_kind = K_SET;
			default:   ident_kind = K_IDENT;
		endcase
	end

	always_comb begin
		mode_n   = mode_q;
		begin_n  = begin_q;
		pos_n    = pos_q;
		line_n   = line_q;
		kw_n     = kw_q;
		b        = '0;
		b.line   = line_q;
		cnt      = 2'd0;
		fall     = 1'b0;
		do_flush = byte_data.end_of_input;
		pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + POS_ONE;
		cur_len  = pos_q - begin_q;
		two      = pos_inc - begin_q;
		line_inc = (line_q == 16'hFFFF) ? line_q : line_q + 16'd1;

		if (!byte_data.end_of_input) begin
			unique case (mode_q)
				M_LPAREN: begin
					if (c == CH_RPAREN) begin
						b.toks[cnt] = '{kind: K_NIL, start: sat16(begin_q), length: sat16(two)};
						cnt = cnt + 2'd1;
						mode_n = M_IDLE;
					end else begin
						fall = 1'b1;
					end
				end
				M_EQ, M_LT, M_GT: begin
					if (c == CH_EQ) begin
						b.toks[cnt].kind = (mode_q == M_EQ) ? K_EQEQ :
							(mode_q == M_LT) ? K_LE : K_GE;
						b.toks[cnt].start  = sat16(begin_q);
						b.toks[cnt].length = sat16(two);
						cnt = cnt + 2'd1;
						mode_n = M_IDLE;
					end else begin
						fall = 1'b1;
					end
				end
				M_NUM: begin
					if (c == CH_DOT) begin
						mode_n = M_NUMDOT;
					end else if (!is_digit(c)) begin
						fall = 1'b1;
					end
				end
				M_NUMDOT: begin
					if (is_digit(c)) begin
						mode_n = M_FRAC;
					end else begin
						fall = 1'b1;
					end
				end
				M_FRAC: begin
					fall = !is_digit(c);
				end
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						kw_n = kw_next(kw_q, lc);
					end else begin
						fall = 1'b1;
					end
				end
				M_STRING: begin
					if (c == CH_DQUOTE) begin
						b.toks[cnt] = '{kind: K_STRING, start: sat16(begin_q), length: sat16(two)};
						cnt = cnt + 2'd1;
						mode_n = M_IDLE;
					end else if (c == CH_LF) begin
						line_n = line_inc;
					end
				end
				M_COMMENT: begin
					fall = (c == CH_LF);
				end
				default: begin
					fall = 1'b1;
				end
			endcase
		end

		if (do_flush || fall) begin
			unique case (mode_q)
				M_LPAREN: begin
					b.toks[cnt] = '{kind: K_LPAREN, start: sat16(begin_q), length: 16'd1};
					cnt = cnt + 2'd1;
				end
				M_EQ: begin
					b.toks[cnt] = '{kind: K_ERRCHAR, start: sat16(begin_q), length: 16'd1};
					cnt = cnt + 2'd1;
				end
				M_LT: begin
					b.toks[cnt] = '{kind: K_LT, start: sat16(begin_q), length: 16'd1};
					cnt = cnt + 2'd1;
				end
				M_GT: begin
					b.toks[cnt] = '{kind: K_GT, start: sat16(begin_q), length: 16'd1};
					cnt = cnt + 2'd1;
				end
				M_NUM, M_FRAC: begin
					b.toks[cnt] = '{kind: K_NUMBER, start: sat16(begin_q), length: sat16(cur_len)};
					cnt = cnt + 2'd1;
				end
				M_NUMDOT: begin
					b.toks[cnt].kind   = K_NUMBER;
					b.toks[cnt].start  = sat16(begin_q);
					b.toks[cnt].length = sat16((cur_len != '0) ? cur_len - POS_ONE : '0);
					cnt = cnt + 2'd1;
					b.toks[cnt].kind   = K_ERRCHAR;
					b.toks[cnt].start  = sat16((pos_q != '0) ? pos_q - POS_ONE : '0);
					b.toks[cnt].length = 16'd1;
					cnt = cnt + 2'd1;
				end
				M_IDENT: begin
					b.toks[cnt] = '{kind: ident_kind, start: sat16(begin_q), length: sat16(cur_len)};
					cnt = cnt + 2'd1;
				end
				M_STRING: begin
					b.toks[cnt] = '{kind: K_ERRSTR, start: sat16(begin_q), length: sat16(cur_len)};
					cnt = cnt + 2'd1;
				end
				default: begin
				end
			endcase
		end

		if (fall) begin
			mode_n  = M_IDLE;
			kw_n    = KW_NONE;
			begin_n = pos_q;
			unique case (c)
				CH_LPAREN: mode_n = M_LPAREN;
				CH_EQ:     mode_n = M_EQ;
				CH_LT:     mode_n = M_LT;
				CH_GT:     mode_n = M_GT;
				CH_SEMI:   mode_n = M_COMMENT;
				CH_DQUOTE: mode_n = M_STRING;
				CH_LF:     line_n = line_inc;
				CH_SPACE, CH_CR, CH_TAB: begin
				end
				CH_RPAREN, CH_MINUS, CH_PLUS, CH_STAR, CH_SLASH, CH_SQUOTE: begin
					unique case (c)
						CH_RPAREN: b.toks[cnt].kind = K_RPAREN;
						CH_MINUS:  b.toks[cnt].kind = K_MINUS;
						CH_PLUS:   b.toks[cnt].kind = K_PLUS;
						CH_STAR:   b.toks[cnt].kind = K_STAR;
						CH_SLASH:  b.toks[cnt].kind = K_SLASH;
						default:   b.toks[cnt].kind = K_QUOTE;
					endcase
					b.toks[cnt].start  = sat16(pos_q);
					b.toks[cnt].length = 16'd1;
					cnt = cnt + 2'd1;
				end
				default: begin
					if (is_digit(c)) begin
						mode_n = M_NUM;
					end else if (is_alpha(c)) begin
						mode_n = M_IDENT;
						kw_n   = kw_first(lc);
					end else begin
						b.toks[cnt] = '{kind: K_ERRCHAR, start: sat16(pos_q), length: 16'd1};
						cnt = cnt + 2'd1;
					end
				end
			endcase
		end

		if (byte_data.end_of_input) begin
			b.toks[cnt] = '{kind: K_END, start: sat16(pos_q), length: 16'd0};
			cnt = cnt + 2'd1;
			mode_n  = M_IDLE;
			begin_n = '0;
			pos_n   = '0;
			line_n  = 16'd1;
			kw_n    = KW_NONE;
		end else begin
			pos_n = pos_inc;
		end
		b.count = cnt;
	end

	assign push   = accept && (cnt != 2'd0);
	assign bundle = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			begin_q <= '0;
			pos_q   <= '0;
			line_q  <= 16'd1;
			kw_q    <= KW_NONE;
		end else if (accept) begin
			mode_q  <= mode_n;
			begin_q <= begin_n;
			pos_q   <= pos_n;
			line_q  <= line_n;
			kw_q    <= kw_n;
		end
	end

endmodule

@@ sv/lts_queue.sv @@
module lts_queue #(
	parameter int DEPTH = lts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lts_pkg::bundle_t wr_data,
	input  logic             pop,
	output lts_pkg::bundle_t rd_data,
	output lts_pkg::q_stat_t stat
);
	import lts_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ sv/lts_back.sv @@
module lts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lts_pkg::q_stat_t q_stat,
	input  lts_pkg::bundle_t head,
	output logic             pop,
	output logic             tok_valid,
	input  logic             tok_stall,
	output lts_pkg::out_t    tok_data
);
	import lts_pkg::*;

	logic [1:0] idx_q;
	logic       val_q;
	out_t       data_q;
	logic       load, take, last;

	assign load = !val_q || !tok_stall;
	assign take = load && !q_stat.empty;
	assign last = (idx_q == head.count - 2'd1);
	assign pop  = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				val_q <= !q_stat.empty;
			end
			if (take) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q.token_kind   <= head.toks[idx_q].kind;
			data_q.token_start  <= head.toks[idx_q].start;
			data_q.token_length <= head.toks[idx_q].length;
			data_q.token_line   <= head.line;
			data_q.last_of_run  <= last;
		end
	end

	assign tok_valid = val_q;
	assign tok_data  = data_q;

endmodule

@@ sv/lisp_token_scanner.sv @@
// Tokens of a completing byte enter the bundle queue, then the output register.
// Throughput: one byte per cycle in; one token per cycle out while tok_stall is low.
// A byte's two or three tokens go out in turn; the bundle queue stalls input when full.
// Reset (arst_n low): scanner idle, position 0, line 1, queue empty, no token valid.
module lisp_token_scanner #(
	parameter int POSITION_BITS = lts_pkg::POSITION_BITS_DEF,
	parameter int QUEUE_DEPTH   = lts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_stall,
	input  lts_pkg::in_t  byte_data,
	output logic          tok_valid,
	input  logic          tok_stall,
	output lts_pkg::out_t tok_data
);
	import lts_pkg::*;

	q_stat_t q_stat;
	bundle_t wr_bundle, head;
	logic    push, pop;

	lts_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_stat     (q_stat),
		.push       (push),
		.bundle     (wr_bundle)
	);

	lts_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.pop     (pop),
		.rd_data (head),
		.stat    (q_stat)
	);

	lts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_data.token_kind == K_END) |-> tok_data.last_of_run)
		else $error("end token not last of its run");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_data.token_line != 16'd0))
		else $error("token line is zero");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty && (head.count != 2'd0))
		else $error("pop from empty queue or empty bundle");

endmodule

@@ dv/lisp_token_scanner_tb.sv @@
`timescale 1ns / 1ps
module lisp_token_scanner_tb;
	import lts_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_LIMIT = 10;
	localparam logic [15:0] POS_TOP = 16'hFFFF;
	localparam logic [15:0] LINE_TOP = 16'hFFFF;

	logic clk;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	in_t byte_data = '0;
	logic tok_valid;
	logic tok_stall = 1'b0;
	out_t tok_data;

	lisp_token_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data(tok_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	mode_t sc_mode;
	logic [15:0] sc_begin;
	logic [15:0] sc_pos;
	logic [15:0] sc_line;
	logic [47:0] sc_word;
	logic [2:0] sc_wlen;

	out_t run_toks[$];
	out_t expected_tokens[$];

	int cycle_count = 0;
	int mismatches = 0;
	int tokens_checked = 0;
	int items_sent = 0;
	int ends_sent = 0;
	int stall_left = 0;
	bit no_idle = 1'b0;
	logic [31:0] seen_kinds = '0;

	function automatic logic [15:0] pos_step(logic [15:0] p);
		return (p == POS_TOP) ? p : p + 16'd1;
	endfunction

	function automatic logic is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "?";
	endfunction

	function automatic logic [7:0] fold_case(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
	endfunction

	function automatic void reset_scan();
		sc_mode = M_IDLE;
		sc_begin = '0;
		sc_pos = '0;
		sc_line = 16'd1;
		sc_word = '0;
		sc_wlen = '0;
	endfunction

	function automatic void clear_word();
		sc_word = '0;
		sc_wlen = '0;
	endfunction

	function automatic void add_char(logic [7:0] c);
		if (sc_wlen < 3'd7) begin
			sc_word = {sc_word[39:0], fold_case(c)};
			sc_wlen++;
		end
	endfunction

	function automatic logic [4:0] word_kind();
		if (sc_wlen == 3'd3 && sc_word[23:0] == "nil")
			return K_NIL;
		if (sc_wlen == 3'd6 && sc_word == "define")
			return K_DEFINE;
		if (sc_wlen == 3'd3 && sc_word[23:0] == "set")
			return K_SET;
		return K_IDENT;
	endfunction

	function automatic void bump_line();
		if (sc_line != LINE_TOP)
			sc_line++;
	endfunction

	function automatic void push_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len);
		out_t t;
		if (run_toks.size() >= TOK_PER_BYTE)
			return;
		t.token_kind = kind;
		t.token_start = start;
		t.token_length = len;
		t.token_line = sc_line;
		t.last_of_run = 1'b0;
		run_toks.insert(run_toks.size(), t);
	endfunction

	function automatic void flush_token();
		logic [15:0] len;
		len = sc_pos - sc_begin;
		case (sc_mode)
			M_LPAREN: push_token(K_LPAREN, sc_begin, 16'd1);
			M_EQ: push_token(K_ERRCHAR, sc_begin, 16'd1);
			M_LT: push_token(K_LT, sc_begin, 16'd1);
			M_GT: push_token(K_GT, sc_begin, 16'd1);
			M_NUM, M_FRAC: push_token(K_NUMBER, sc_begin, len);
			M_NUMDOT: begin
				push_token(K_NUMBER, sc_begin, (len > 0) ? len - 16'd1 : 16'd0);
				push_token(K_ERRCHAR, (sc_pos > 0) ? sc_pos - 16'd1 : 16'd0, 16'd1);
			end
			M_IDENT: push_token(word_kind(), sc_begin, len);
			M_STRING: push_token(K_ERRSTR, sc_begin, len);
			default: ;
		endcase
		sc_mode = M_IDLE;
		clear_word();
	endfunction

	function automatic void start_token(logic [7:0] c);
		sc_begin = sc_pos;
		sc_mode = M_IDLE;
		case (c)
			"(": sc_mode = M_LPAREN;
			")": push_token(K_RPAREN, sc_pos, 16'd1);
			"-": push_token(K_MINUS, sc_pos, 16'd1);
			"+": push_token(K_PLUS, sc_pos, 16'd1);
			"*": push_token(K_STAR, sc_pos, 16'd1);
			"/": push_token(K_SLASH, sc_pos, 16'd1);
			"=": sc_mode = M_EQ;
			"<": sc_mode = M_LT;
			">": sc_mode = M_GT;
			";": sc_mode = M_COMMENT;
			" ", "\t", 8'h0D: ;
			"\n": bump_line();
			"\"": sc_mode = M_STRING;
			"'": push_token(K_QUOTE, sc_pos, 16'd1);
			default: begin
				if (is_num(c)) begin
					sc_mode = M_NUM;
				end else if (is_letter(c)) begin
					sc_mode = M_IDENT;
					clear_word();
					add_char(c);
				end else begin
					push_token(K_ERRCHAR, sc_pos, 16'd1);
				end
			end
		endcase
	endfunction

	function automatic void predict_byte(logic [7:0] c);
		logic [15:0] two;
		two = pos_step(sc_pos) - sc_begin;
		case (sc_mode)
			M_LPAREN: if (c == ")") begin
				push_token(K_NIL, sc_begin, two);
				sc_mode = M_IDLE;
				return;
			end
			M_EQ: if (c == "=") begin
				push_token(K_EQEQ, sc_begin, two);
				sc_mode = M_IDLE;
				return;
			end
			M_LT: if (c == "=") begin
				push_token(K_LE, sc_begin, two);
				sc_mode = M_IDLE;
				return;
			end
			M_GT: if (c == "=") begin
				push_token(K_GE, sc_begin, two);
				sc_mode = M_IDLE;
				return;
			end
			M_NUM: begin
				if (is_num(c))
					return;
				if (c == ".") begin
					sc_mode = M_NUMDOT;
					return;
				end
			end
			M_NUMDOT: if (is_num(c)) begin
				sc_mode = M_FRAC;
				return;
			end
			M_FRAC: if (is_num(c))
				return;
			M_IDENT: if (is_letter(c) || is_num(c)) begin
				add_char(c);
				return;
			end
			M_STRING: begin
				if (c == "\"") begin
					push_token(K_STRING, sc_begin, two);
					sc_mode = M_IDLE;
					return;
				end
				if (c == "\n")
					bump_line();
				return;
			end
			M_COMMENT: begin
				if (c != "\n")
					return;
				sc_mode = M_IDLE;
			end
			default: ;
		endcase
		flush_token();
		start_token(c);
	endfunction

	function automatic void predict_item(in_t it);
		run_toks.delete();
		if (it.end_of_input) begin
			flush_token();
			push_token(K_END, sc_pos, 16'd0);
			reset_scan();
		end else begin
			predict_byte(it.char_code);
			sc_pos = pos_step(sc_pos);
		end
		if (run_toks.size() > 0)
			run_toks[run_toks.size() - 1].last_of_run = 1'b1;
		foreach (run_toks[i])
			expected_tokens.insert(expected_tokens.size(), run_toks[i]);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 99)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (!arst_n || no_idle) begin
			tok_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			tok_stall <= 1'b1;
			stall_left--;
		end else begin
			stall_left = pick_gap();
			if (stall_left > 0) begin
				tok_stall <= 1'b1;
				stall_left--;
			end else begin
				tok_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected token: kind %0d start %0d length %0d line %0d last %0b",
						tok_data.token_kind, tok_data.token_start, tok_data.token_length,
						tok_data.token_line, tok_data.last_of_run);
			end else begin
				want = expected_tokens.pop_front();
				tokens_checked++;
				seen_kinds[tok_data.token_kind] = 1'b1;
				if (tok_data !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("token %0d expected: kind %0d start %0d length %0d line %0d last %0b",
							tokens_checked, want.token_kind, want.token_start,
							want.token_length, want.token_line, want.last_of_run);
						$display("token %0d actual:   kind %0d start %0d length %0d line %0d last %0b",
							tokens_checked, tok_data.token_kind, tok_data.token_start,
							tok_data.token_length, tok_data.token_line, tok_data.last_of_run);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
				expected_tokens.size());
			$display("lisp_token_scanner_tb failed");
			$finish;
		end
	end

	task automatic send_item(input in_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= it;
		do @(posedge clk); while (byte_stall);
		predict_item(it);
		items_sent++;
		if (it.end_of_input)
			ends_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c);
		in_t it;
		it.char_code = c;
		it.end_of_input = 1'b0;
		send_item(it);
	endtask

	task automatic send_end();
		in_t it;
		it.char_code = 8'($urandom_range(0, 255));
		it.end_of_input = 1'b1;
		send_item(it);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// hold the sender until every outstanding token has been checked
	task automatic hold_input();
		byte_valid <= 1'b0;
		do @(negedge clk); while (expected_tokens.size() != 0);
	endtask

	function automatic logic [7:0] any_letter();
		int r;
		r = $urandom_range(0, 53);
		if (r < 26)
			return 8'(r) + "a";
		if (r < 52)
			return 8'(r - 26) + "A";
		if (r == 52)
			return "_";
		return "?";
	endfunction

	function automatic logic [7:0] any_digit();
		return 8'($urandom_range(0, 9)) + "0";
	endfunction

	task automatic send_word();
		string kw;
		int r;
		int n;
		logic [7:0] c;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			case ($urandom_range(0, 2))
				0: kw = "nil";
				1: kw = "define";
				default: kw = "set";
			endcase
			n = (r == 3) ? kw.len() - 1 : kw.len();
			for (int i = 0; i < n; i++) begin
				c = kw[i];
				if ($urandom_range(0, 1))
					c = c ^ 8'h20;
				send_byte(c);
			end
			if (r == 4)
				send_byte($urandom_range(0, 1) ? any_digit() : any_letter());
		end else begin
			send_byte(any_letter());
			n = $urandom_range(0, 6);
			repeat (n) send_byte(($urandom_range(0, 3) == 0) ? any_digit() : any_letter());
		end
	endtask

	task automatic send_number();
		int r;
		r = $urandom_range(0, 3);
		repeat ($urandom_range(1, 4)) send_byte(any_digit());
		if (r == 2) begin
			send_byte(".");
			repeat ($urandom_range(1, 3)) send_byte(any_digit());
		end else if (r == 3) begin
			send_byte(".");
		end
	endtask

	task automatic send_string();
		logic [7:0] c;
		send_byte("\"");
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(0, 9) == 0) begin
				c = "\n";
			end else begin
				do c = 8'($urandom_range(0, 255)); while (c == "\"");
			end
			send_byte(c);
		end
		if ($urandom_range(0, 9) != 0)
			send_byte("\"");
		else
			send_end();
	endtask

	task automatic send_operator();
		case ($urandom_range(0, 13))
			0: send_text("(");
			1: send_text(")");
			2: send_text("()");
			3: send_text("-");
			4: send_text("+");
			5: send_text("*");
			6: send_text("/");
			7: send_text("==");
			8: send_text("<");
			9: send_text("<=");
			10: send_text(">");
			11: send_text(">=");
			12: send_text("'");
			default: send_text("=");
		endcase
	endtask

	task automatic send_comment();
		logic [7:0] c;
		send_byte(";");
		repeat ($urandom_range(0, 8)) begin
			do c = 8'($urandom_range(0, 255)); while (c == "\n");
			send_byte(c);
		end
		if ($urandom_range(0, 6) != 0)
			send_byte("\n");
		else
			send_end();
	endtask

	task automatic send_blank();
		case ($urandom_range(0, 3))
			0: send_byte(" ");
			1: send_byte("\t");
			2: send_byte(8'h0D);
			default: send_byte("\n");
		endcase
	endtask

	task automatic test_delimiters();
		send_text("(()')(");
		send_end();
	endtask

	task automatic test_operators();
		send_text("-+*/==<<=>>=>");
		send_end();
	endtask

	task automatic test_literals();
		send_text("\"x\ny\"42.5 7.)9.");
		send_end();
	endtask

	task automatic test_errors();
		send_text("=a");
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h00);
		send_text(";x");
		send_end();
		send_text("\"ab");
		send_end();
	endtask

	task automatic test_random_text();
		int first_item;
		int r;
		bit paused;
		first_item = items_sent;
		paused = 1'b0;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				send_word();
			else if (r < 35)
				send_number();
			else if (r < 45)
				send_string();
			else if (r < 65)
				send_operator();
			else if (r < 72)
				send_comment();
			else if (r < 80)
				send_byte(8'($urandom_range(0, 255)));
			else
				send_blank();
			if ($urandom_range(0, 1))
				send_blank();
			if ($urandom_range(0, 24) == 0)
				send_end();
			if ($urandom_range(0, 29) == 0)
				no_idle = ~no_idle;
			if (!paused && items_sent - first_item >= RANDOM_ITEMS / 2) begin
				hold_input();
				paused = 1'b1;
			end
		end
		send_end();
		no_idle = 1'b0;
	endtask

	initial begin
		reset_scan();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_delimiters();
		test_operators();
		test_literals();
		test_errors();
		hold_input();
		test_random_text();
		hold_input();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d bytes and %0d end-of-input items, %0d tokens checked",
			items_sent - ends_sent, ends_sent, tokens_checked);
		$display("%0d token kinds seen over directed and random text with gaps on both sides",
			$countones(seen_kinds));
		if (mismatches == 0 && expected_tokens.size() == 0) begin
			$display("lisp_token_scanner_tb passed");
		end else begin
			$display("%0d mismatches, %0d tokens outstanding", mismatches,
				expected_tokens.size());
			$display("lisp_token_scanner_tb failed");
		end
		$finish;
	end

endmodule
